// ----- sv/dss_pkg.sv -----
// Shared constants, codes, state type and control structs of the delay-and-sum stacker.
package dss_pkg;

	localparam int MAX_CHANNELS_DEF = 64;
	localparam int MAX_SAMPLES_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF  = 16;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 24;
	localparam int VALUE_W    = 23;
	localparam int CFG_W      = 32;
	localparam int SUM_MAX    = 4194303;
	localparam int SUM_MIN    = -4194304;

	localparam logic [1:0] OP_LOAD_SAMPLE  = 2'd0;
	localparam logic [1:0] OP_LOAD_ARRIVAL = 2'd1;
	localparam logic [1:0] OP_STACK        = 2'd2;
	localparam logic [1:0] OP_QUERY        = 2'd3;

	localparam logic [1:0] CFG_START_TIME    = 2'd0;
	localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd1;
	localparam logic [1:0] CFG_CHANNELS_USED = 2'd2;
	localparam logic [1:0] CFG_SAMPLES_USED  = 2'd3;

	localparam logic KIND_STACK = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QWAIT,
		ST_QOUT,
		ST_TOF0W,
		ST_TOF0,
		ST_RDIV,
		ST_CHRD,
		ST_CHST,
		ST_CHDIV,
		ST_ACC,
		ST_ADRAIN,
		ST_FIN,
		ST_FDRAIN,
		ST_SOUT
	} state_t;

	typedef struct packed {
		logic wr_amp;
		logic wr_arr;
		logic q_start;
		logic q_out;
		logic st_start;
		logic tof0;
		logic ref_done;
		logic ch_div;
		logic d_latch;
		logic acc_step;
		logic ch_next;
		logic fin_step;
		logic s_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic div_done;
		logic div_busy;
		logic j_last_acc;
		logic j_last_fin;
		logic ch_last;
		logic skip_acc;
	} sts_t;

endpackage

// ----- sv/delay_and_sum_stacker_top.sv -----
// Top level of the delay-and-sum stacker.
// Input items arrive on s_tvalid/s_tready with the operation in s_tuser.
// Sample and arrival-time loads give no result, so they stream in at one
// item per cycle while no query or stack runs. A query registers its sum
// address, reads the sum memory and loads one result item into the output
// register. A stack command reads the first arrival time and divides for
// the reference index, then for each channel in use reads its arrival time,
// divides for its delay and accumulates each of its samples, then makes a
// final pass over the sum memory that saturates every sum in use, zeroes the
// rest and finds the peak, which is the result item. The divider and the
// single sum memory port set the pace of a stack. No item is taken while a
// query or stack runs. Results sit in an output register on m_tvalid/m_tready;
// while it is held by a stalled receiver, loads are still accepted and a
// finished query or stack waits. Reset clears the configuration to its
// defaults, empties the output register and makes every query read zero until
// the first stack; the sample and arrival stores hold nothing defined until written.
module delay_and_sum_stacker_top #(
	parameter int MAX_CHANNELS = dss_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_SAMPLES  = dss_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS  = dss_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [dss_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// channel, sample_index, amplitude, arrival_time, offset
	input  logic [dss_pkg::IN_DATA_W-1:0]  s_tdata,
	// op
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// value
	output logic [dss_pkg::OUT_DATA_W-1:0] m_tdata,
	// result_kind, outside
	output logic [1:0]                     m_tuser
);

	dss_pkg::cmd_t cmd;
	dss_pkg::sts_t sts;

	dss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (s_tuser),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	dss_dp #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.MAX_SAMPLES  (MAX_SAMPLES),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ----- sv/dss_ram.sv -----
// Generic single-port-write RAM with one registered read port.
module dss_ram #(
	parameter int W = 16,
	parameter int D = 1024,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/dss_div.sv -----
// Restoring divider, one quotient bit per cycle, signed result truncated toward zero.
module dss_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               neg,
	input  logic [31:0]        num_mag,
	input  logic [31:0]        den,
	output logic               busy,
	output logic               done,
	output logic signed [32:0] quot
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] r2;
	logic        ge;

	assign r2 = {rem_q, quo_q[31]};
	assign ge = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num_mag;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ----- sv/dss_dp.sv -----
// Datapath: configuration, stores, divider, accumulation, peak search and output register.
module dss_dp #(
	parameter int MAX_CHANNELS = dss_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_SAMPLES  = dss_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS  = dss_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [dss_pkg::CFG_W-1:0]      cfg_data,
	input  logic [dss_pkg::IN_DATA_W-1:0]  s_tdata,
	input  dss_pkg::cmd_t                  cmd,
	output dss_pkg::sts_t                  sts,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dss_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]                     m_tuser
);

	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int SMP_W  = $clog2(MAX_SAMPLES);
	localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
	localparam int NT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int AMP_D  = MAX_CHANNELS * MAX_SAMPLES;
	localparam int AMP_AW = $clog2(AMP_D);
	localparam int ACC_W  = (SAMPLE_BITS + CH_W + 1 > 24) ? SAMPLE_BITS + CH_W + 1 : 24;
	localparam int LIM    = 1 << (SAMPLE_BITS - 1);
	localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(dss_pkg::SUM_MAX);
	localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(dss_pkg::SUM_MIN);

	logic [31:0]       start_q;
	logic [31:0]       period_q;
	logic [6:0]        chans_q;
	logic [10:0]       samps_q;
	logic [NCH_W-1:0]  nch_cl;
	logic [NT_W-1:0]   nt_cl;
	logic [NCH_W-1:0]  nch_q;
	logic [NT_W-1:0]   nt_q;
	logic [31:0]       dt_q;
	logic [31:0]       tof0_q;
	logic signed [31:0] ref_q;
	logic signed [32:0] d_q;
	logic [CH_W-1:0]   ch_q;
	logic [SMP_W-1:0]  j_q;
	logic [SMP_W-1:0]  qaddr_q;
	logic              qout_q;
	logic              stacked_q;
	logic [22:0]       peak_q;

	logic              acc_s1;
	logic              fin_s1;
	logic              first_s1;
	logic              inr_s1;
	logic              keep_s1;
	logic [SMP_W-1:0]  j_s1;

	logic              mvalid_q;
	logic [22:0]       value_q;
	logic              kind_q;
	logic              outside_q;

	logic [5:0]        in_ch;
	logic [9:0]        in_si;
	logic signed [15:0] in_amp;
	logic [31:0]       in_arr;
	logic signed [10:0] in_off;
	logic signed [31:0] amp_cl;
	logic              amp_ok;
	logic              arr_ok;

	logic [AMP_AW-1:0] amp_waddr;
	logic [AMP_AW-1:0] amp_raddr;
	logic [SAMPLE_BITS-1:0] amp_rdata;
	logic [31:0]       arr_rdata;
	logic [SMP_W-1:0]  sum_raddr;
	logic [ACC_W-1:0]  sum_rdata;
	logic              sum_we;
	logic [ACC_W-1:0]  sum_wdata;

	logic signed [32:0] diff;
	logic [31:0]       div_mag;
	logic              div_start;
	logic signed [32:0] quot;
	logic              div_busy;
	logic              div_done;

	logic signed [34:0] jd;
	logic              inr;
	logic signed [32:0] qm;
	logic              q_outside;
	logic signed [ACC_W-1:0] acc_sum;
	logic signed [ACC_W-1:0] clamped;
	logic [22:0]       mag;
	logic              out_free;

	assign in_ch  = s_tdata[5:0];
	assign in_si  = s_tdata[15:6];
	assign in_amp = s_tdata[31:16];
	assign in_arr = s_tdata[63:32];
	assign in_off = s_tdata[74:64];

	assign nch_cl = (int'(chans_q) > MAX_CHANNELS) ? NCH_W'(MAX_CHANNELS) : NCH_W'(chans_q);
	assign nt_cl  = (int'(samps_q) > MAX_SAMPLES) ? NT_W'(MAX_SAMPLES) : NT_W'(samps_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			period_q <= 32'd1;
			chans_q  <= 7'd64;
			samps_q  <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				dss_pkg::CFG_START_TIME:    start_q  <= cfg_data;
				dss_pkg::CFG_SAMPLE_PERIOD: period_q <= cfg_data;
				dss_pkg::CFG_CHANNELS_USED: chans_q  <= cfg_data[6:0];
				dss_pkg::CFG_SAMPLES_USED:  samps_q  <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Sample amplitudes are saturated to the stored sample width.
	always_comb begin
		if (int'(in_amp) > LIM - 1) begin
			amp_cl = LIM - 1;
		end else if (int'(in_amp) < -LIM) begin
			amp_cl = -LIM;
		end else begin
			amp_cl = 32'(in_amp);
		end
	end

	assign amp_ok    = (int'(in_ch) < MAX_CHANNELS) && (int'(in_si) < MAX_SAMPLES);
	assign arr_ok    = int'(in_ch) < MAX_CHANNELS;
	assign amp_waddr = AMP_AW'(AMP_AW'(in_ch) * AMP_AW'(MAX_SAMPLES) + AMP_AW'(in_si));

	assign jd  = 35'($signed({1'b0, j_q})) + 35'(d_q);
	assign inr = !jd[34] && (jd < $signed(35'(nt_q)));
	assign amp_raddr = AMP_AW'(AMP_AW'(ch_q) * AMP_AW'(MAX_SAMPLES) + AMP_AW'(jd[SMP_W-1:0]));

	dss_ram #(.W(SAMPLE_BITS), .D(AMP_D)) u_amp (
		.clk   (clk),
		.we    (cmd.wr_amp && amp_ok),
		.waddr (amp_waddr),
		.wdata (SAMPLE_BITS'(amp_cl)),
		.raddr (amp_raddr),
		.rdata (amp_rdata)
	);

	dss_ram #(.W(32), .D(MAX_CHANNELS)) u_arr (
		.clk   (clk),
		.we    (cmd.wr_arr && arr_ok),
		.waddr (CH_W'(in_ch)),
		.wdata (in_arr),
		.raddr (ch_q),
		.rdata (arr_rdata)
	);

	assign sum_raddr = (cmd.acc_step || cmd.fin_step) ? j_q : qaddr_q;

	dss_ram #(.W(ACC_W), .D(MAX_SAMPLES)) u_sum (
		.clk   (clk),
		.we    (sum_we),
		.waddr (j_s1),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	assign diff = cmd.tof0 ? $signed({1'b0, arr_rdata}) - $signed({1'b0, start_q})
	                       : $signed({1'b0, arr_rdata}) - $signed({1'b0, tof0_q});
	assign div_mag   = diff[32] ? 32'(-diff) : diff[31:0];
	assign div_start = cmd.tof0 || cmd.ch_div;

	dss_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.neg     (diff[32]),
		.num_mag (div_mag),
		.den     (dt_q),
		.busy    (div_busy),
		.done    (div_done),
		.quot    (quot)
	);

	assign qm = 33'(in_off) + 33'(ref_q);
	assign q_outside = qm[32] || (qm >= $signed(33'(nt_cl)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q     <= '0;
			stacked_q <= 1'b0;
			acc_s1    <= 1'b0;
			fin_s1    <= 1'b0;
		end else begin
			acc_s1 <= cmd.acc_step;
			fin_s1 <= cmd.fin_step;
			if (cmd.st_start) begin
				stacked_q <= 1'b1;
			end
			if (cmd.ref_done) begin
				if (quot[32] != quot[31]) begin
					ref_q <= quot[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				end else begin
					ref_q <= quot[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			qaddr_q <= qm[SMP_W-1:0];
			qout_q  <= q_outside;
		end
		if (cmd.st_start) begin
			nch_q  <= nch_cl;
			nt_q   <= nt_cl;
			dt_q   <= (period_q == '0) ? 32'd1 : period_q;
			ch_q   <= '0;
			peak_q <= '0;
		end
		if (cmd.tof0) begin
			tof0_q <= arr_rdata;
		end
		if (cmd.d_latch) begin
			d_q <= quot;
		end
		if (cmd.ch_next) begin
			ch_q <= ch_q + CH_W'(1);
		end
		if (cmd.ref_done || cmd.d_latch || cmd.ch_next) begin
			j_q <= '0;
		end else if (cmd.acc_step || cmd.fin_step) begin
			j_q <= j_q + SMP_W'(1);
		end
		j_s1     <= j_q;
		first_s1 <= ch_q == '0;
		inr_s1   <= inr;
		keep_s1  <= (nch_q != '0) && ($signed({1'b0, j_q}) < $signed({1'b0, nt_q}));
		if (fin_s1) begin
			if (mag > peak_q) begin
				peak_q <= mag;
			end
		end
	end

	assign acc_sum = (first_s1 ? ACC_W'(0) : $signed(sum_rdata))
	               + (inr_s1 ? ACC_W'($signed(amp_rdata)) : ACC_W'(0));

	always_comb begin
		if (!keep_s1) begin
			clamped = '0;
		end else if ($signed(sum_rdata) > ACC_HI) begin
			clamped = ACC_HI;
		end else if ($signed(sum_rdata) < ACC_LO) begin
			clamped = ACC_LO;
		end else begin
			clamped = $signed(sum_rdata);
		end
	end

	assign mag       = clamped[ACC_W-1] ? 23'(-clamped) : 23'(clamped);
	assign sum_we    = acc_s1 || fin_s1;
	assign sum_wdata = fin_s1 ? clamped : acc_sum;

	assign out_free = !mvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (cmd.q_out || cmd.s_out) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_out) begin
			value_q   <= (stacked_q && !qout_q) ? sum_rdata[22:0] : '0;
			kind_q    <= dss_pkg::KIND_QUERY;
			outside_q <= qout_q;
		end else if (cmd.s_out) begin
			value_q   <= (peak_q > 23'(dss_pkg::SUM_MAX)) ? 23'(dss_pkg::SUM_MAX) : peak_q;
			kind_q    <= dss_pkg::KIND_STACK;
			outside_q <= 1'b0;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {1'b0, value_q};
	assign m_tuser  = {outside_q, kind_q};

	assign sts.out_free   = out_free;
	assign sts.div_done   = div_done;
	assign sts.div_busy   = div_busy;
	assign sts.j_last_acc = (int'(j_q) + 1) == int'(nt_q);
	assign sts.j_last_fin = int'(j_q) == MAX_SAMPLES - 1;
	assign sts.ch_last    = (int'(ch_q) + 1) == int'(nch_q);
	assign sts.skip_acc   = (nch_q == '0) || (nt_q == '0);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.q_out || cmd.s_out) |-> out_free)
		else $error("output register loaded while occupied");
	a_acc_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_step |-> !div_busy)
		else $error("accumulation while divider busy");
	a_no_raw: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_s1 && cmd.acc_step) |-> (j_s1 != j_q))
		else $error("sum read collides with pending write");

endmodule

// ----- sv/dss_ctrl.sv -----
// Controller state machine sequencing loads, queries and the stack pass.
module dss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic [1:0]    op,
	input  dss_pkg::sts_t sts,
	output logic          s_tready,
	output dss_pkg::cmd_t cmd
);

	dss_pkg::state_t state_q;
	dss_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dss_pkg::ST_IDLE: begin
				if (s_tvalid && op == dss_pkg::OP_QUERY) begin
					state_d = dss_pkg::ST_QWAIT;
				end else if (s_tvalid && op == dss_pkg::OP_STACK) begin
					state_d = dss_pkg::ST_TOF0W;
				end
			end
			dss_pkg::ST_QWAIT: state_d = dss_pkg::ST_QOUT;
			dss_pkg::ST_QOUT: begin
				if (sts.out_free) begin
					state_d = dss_pkg::ST_IDLE;
				end
			end
			dss_pkg::ST_TOF0W: state_d = dss_pkg::ST_TOF0;
			dss_pkg::ST_TOF0:  state_d = dss_pkg::ST_RDIV;
			dss_pkg::ST_RDIV: begin
				if (sts.div_done) begin
					state_d = sts.skip_acc ? dss_pkg::ST_FIN : dss_pkg::ST_CHRD;
				end
			end
			dss_pkg::ST_CHRD: state_d = dss_pkg::ST_CHST;
			dss_pkg::ST_CHST: state_d = dss_pkg::ST_CHDIV;
			dss_pkg::ST_CHDIV: begin
				if (sts.div_done) begin
					state_d = dss_pkg::ST_ACC;
				end
			end
			dss_pkg::ST_ACC: begin
				if (sts.j_last_acc) begin
					state_d = dss_pkg::ST_ADRAIN;
				end
			end
			dss_pkg::ST_ADRAIN: state_d = sts.ch_last ? dss_pkg::ST_FIN : dss_pkg::ST_CHRD;
			dss_pkg::ST_FIN: begin
				if (sts.j_last_fin) begin
					state_d = dss_pkg::ST_FDRAIN;
				end
			end
			dss_pkg::ST_FDRAIN: state_d = dss_pkg::ST_SOUT;
			dss_pkg::ST_SOUT: begin
				if (sts.out_free) begin
					state_d = dss_pkg::ST_IDLE;
				end
			end
			default: state_d = dss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			dss_pkg::ST_IDLE: begin
				s_tready     = 1'b1;
				cmd.wr_amp   = s_tvalid && op == dss_pkg::OP_LOAD_SAMPLE;
				cmd.wr_arr   = s_tvalid && op == dss_pkg::OP_LOAD_ARRIVAL;
				cmd.st_start = s_tvalid && op == dss_pkg::OP_STACK;
				cmd.q_start  = s_tvalid && op == dss_pkg::OP_QUERY;
			end
			dss_pkg::ST_QOUT:   cmd.q_out = sts.out_free;
			dss_pkg::ST_TOF0:   cmd.tof0 = 1'b1;
			dss_pkg::ST_RDIV:   cmd.ref_done = sts.div_done;
			dss_pkg::ST_CHST:   cmd.ch_div = 1'b1;
			dss_pkg::ST_CHDIV:  cmd.d_latch = sts.div_done;
			dss_pkg::ST_ACC:    cmd.acc_step = 1'b1;
			dss_pkg::ST_ADRAIN: cmd.ch_next = 1'b1;
			dss_pkg::ST_FIN:    cmd.fin_step = 1'b1;
			dss_pkg::ST_SOUT:   cmd.s_out = sts.out_free;
			default: ;
		endcase
	end

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != dss_pkg::ST_IDLE) |-> !s_tready)
		else $error("item accepted during a running command");
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.acc_step && cmd.fin_step))
		else $error("accumulate and final pass overlap");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd.d_latch) |-> $past(state_q) == dss_pkg::ST_CHDIV || $past(state_q) == dss_pkg::ST_CHST)
		else $error("delay latched outside divide wait");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the delay-and-sum stacker: directed and random items against a predictor.
`timescale 1ns / 1ps

module testbench;

	localparam int NCH = dss_pkg::MAX_CHANNELS_DEF;
	localparam int NSMP = dss_pkg::MAX_SAMPLES_DEF;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int SETTLE = 40;

	typedef struct {
		logic signed [dss_pkg::VALUE_W-1:0] value;
		logic kind;
		logic outside;
	} beam_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [dss_pkg::CFG_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [dss_pkg::IN_DATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [dss_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;

	logic [31:0] start_ticks;
	logic [31:0] period_ticks;
	logic [6:0] chan_count;
	logic [10:0] smp_count;
	logic signed [15:0] trace_mem [NCH][NSMP];
	bit trace_ok [NCH][NSMP];
	logic [31:0] tof_mem [NCH];
	bit tof_ok [NCH];
	logic signed [dss_pkg::VALUE_W-1:0] beam_sums [NSMP];
	longint ref_sample;

	beam_result_t pending_results[$];
	int errors;
	int items_sent;
	int stacks_sent;
	int queries_sent;
	int results_seen;
	bit no_gaps;
	longint cycles;

	delay_and_sum_stacker_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int eff_channels();
		return chan_count > NCH ? NCH : int'(chan_count);
	endfunction

	function automatic int eff_samples();
		return smp_count > NSMP ? NSMP : int'(smp_count);
	endfunction

	// Works out the effect of one accepted item and queues its result, if any.
	function automatic void predict_beam(logic [1:0] op, logic [5:0] ch, logic [9:0] si,
			logic signed [15:0] amp, logic [31:0] tof, logic signed [10:0] off);
		longint acc [NSMP];
		longint dt, tof0, d, jd, s, mag, peak, idx;
		int nch, nt;
		beam_result_t r;
		nch = eff_channels();
		nt = eff_samples();
		dt = (period_ticks == 0) ? 1 : longint'(period_ticks);
		case (op)
			dss_pkg::OP_LOAD_SAMPLE: begin
				trace_mem[ch][si] = amp;
				trace_ok[ch][si] = 1'b1;
			end
			dss_pkg::OP_LOAD_ARRIVAL: begin
				tof_mem[ch] = tof;
				tof_ok[ch] = 1'b1;
			end
			dss_pkg::OP_STACK: begin
				tof0 = longint'(tof_mem[0]);
				ref_sample = (tof0 - longint'(start_ticks)) / dt;
				if (ref_sample > 64'sd2147483647) ref_sample = 64'sd2147483647;
				if (ref_sample < -64'sd2147483648) ref_sample = -64'sd2147483648;
				for (int j = 0; j < NSMP; j++) acc[j] = 0;
				for (int i = 0; i < nch; i++) begin
					d = (longint'(tof_mem[i]) - tof0) / dt;
					for (int j = 0; j < nt; j++) begin
						jd = j + d;
						if (jd >= 0 && jd <= nt - 1) acc[j] += longint'(trace_mem[i][jd]);
					end
				end
				peak = 0;
				for (int j = 0; j < NSMP; j++) begin
					s = (j < nt) ? acc[j] : 0;
					if (s > dss_pkg::SUM_MAX) s = dss_pkg::SUM_MAX;
					if (s < dss_pkg::SUM_MIN) s = dss_pkg::SUM_MIN;
					beam_sums[j] = s[dss_pkg::VALUE_W-1:0];
					mag = s < 0 ? -s : s;
					if (mag > peak) peak = mag;
				end
				if (peak > dss_pkg::SUM_MAX) peak = dss_pkg::SUM_MAX;
				r.value = peak[dss_pkg::VALUE_W-1:0];
				r.kind = dss_pkg::KIND_STACK;
				r.outside = 1'b0;
				pending_results.push_back(r);
			end
			default: begin
				idx = longint'(off) + ref_sample;
				r.kind = dss_pkg::KIND_QUERY;
				if (idx < 0 || idx > nt - 1) begin
					r.value = '0;
					r.outside = 1'b1;
				end else begin
					r.value = beam_sums[idx];
					r.outside = 1'b0;
				end
				pending_results.push_back(r);
			end
		endcase
	endfunction

	task automatic send_item(logic [1:0] op, logic [5:0] ch, logic [9:0] si,
			logic signed [15:0] amp, logic [31:0] tof, logic signed [10:0] off);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'b0, off, tof, amp, si, ch};
		do @(posedge clk); while (!s_tready);
		predict_beam(op, ch, si, amp, tof, off);
		items_sent++;
		if (op == dss_pkg::OP_STACK) stacks_sent++;
		if (op == dss_pkg::OP_QUERY) queries_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dss_pkg::CFG_START_TIME: start_ticks = val;
			dss_pkg::CFG_SAMPLE_PERIOD: period_ticks = val;
			dss_pkg::CFG_CHANNELS_USED: chan_count = val[6:0];
			default: smp_count = val[10:0];
		endcase
	endtask

	task automatic set_geometry(logic [31:0] st, logic [31:0] per, int nch, int nt);
		wait_idle();
		cfg_write(dss_pkg::CFG_START_TIME, st);
		cfg_write(dss_pkg::CFG_SAMPLE_PERIOD, per);
		cfg_write(dss_pkg::CFG_CHANNELS_USED, nch);
		cfg_write(dss_pkg::CFG_SAMPLES_USED, nt);
	endtask

	task automatic load_trace(int ch, int si, logic signed [15:0] amp);
		send_item(dss_pkg::OP_LOAD_SAMPLE, 6'(ch), 10'(si), amp, $urandom, 11'($urandom));
	endtask

	task automatic load_tof(int ch, logic [31:0] tof);
		send_item(dss_pkg::OP_LOAD_ARRIVAL, 6'(ch), 10'($urandom), 16'($urandom), tof,
			11'($urandom));
	endtask

	task automatic query_sum(int off);
		send_item(dss_pkg::OP_QUERY, 6'($urandom), 10'($urandom), 16'($urandom), $urandom,
			11'(off));
	endtask

	// The stack reads every sample and arrival time in use, so anything not yet loaded is filled first.
	task automatic stack_beam();
		int nch, nt;
		nch = eff_channels();
		nt = eff_samples();
		if (!tof_ok[0]) load_tof(0, 32'd1000 + $urandom_range(0, 40));
		for (int i = 0; i < nch; i++) begin
			if (!tof_ok[i]) load_tof(i, 32'd1000 + $urandom_range(0, 40));
			for (int j = 0; j < nt; j++)
				if (!trace_ok[i][j]) load_trace(i, j, 16'($urandom));
		end
		send_item(dss_pkg::OP_STACK, 6'($urandom), 10'($urandom), 16'($urandom), $urandom,
			11'($urandom));
	endtask

	always begin
		int n;
		n = no_gaps ? 0 : $urandom_range(0, 6);
		if (n > 0) begin
			m_tready <= 1'b0;
			repeat (n) @(posedge clk);
		end
		m_tready <= 1'b1;
		do @(posedge clk); while (!(m_tvalid && m_tready && arst_n));
	end

	always @(posedge clk) begin
		beam_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: value %0d kind %0b outside %0b",
					$signed(m_tdata[dss_pkg::VALUE_W-1:0]), m_tuser[0], m_tuser[1]);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[dss_pkg::VALUE_W-1:0] !== want.value) begin
					$error("value: expected %0d, actual %0d", want.value,
						$signed(m_tdata[dss_pkg::VALUE_W-1:0]));
					errors++;
				end
				if (m_tuser[0] !== want.kind) begin
					$error("result_kind: expected %0b, actual %0b", want.kind, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== want.outside) begin
					$error("outside: expected %0b, actual %0b", want.outside, m_tuser[1]);
					errors++;
				end
			end
		end
	end

	task automatic test_reset_state();
		query_sum(0);
		query_sum(1023);
		query_sum(-1);
		query_sum(-1024);
	endtask

	task automatic test_all_channels();
		set_geometry(32'd4998, 32'd1, NCH, 4);
		no_gaps = 1'b1;
		load_tof(0, 32'd5000);
		for (int i = 1; i < NCH - 1; i++) load_tof(i, 32'd4997 + $urandom_range(0, 6));
		load_tof(NCH - 1, 32'hFFFF_FFFF);
		for (int i = 0; i < NCH; i++)
			for (int j = 0; j < 4; j++) load_trace(i, j, 16'($urandom));
		no_gaps = 1'b0;
		stack_beam();
		query_sum(0);
		query_sum(1);
		query_sum(-2);
		query_sum(2);
		query_sum(-3);
	endtask

	task automatic test_saturation();
		set_geometry(32'd0, 32'd1, NCH, 2);
		for (int i = 0; i < NCH; i++) begin
			load_tof(i, 32'd0);
			for (int j = 0; j < 2; j++) load_trace(i, j, 16'sh8000);
		end
		stack_beam();
		query_sum(0);
		query_sum(2);
		for (int i = 0; i < NCH; i++) load_trace(i, 1, 16'sh7FFF);
		stack_beam();
		query_sum(1);
	endtask

	task automatic test_timing_edges();
		set_geometry(32'hFFFF_FFFF, 32'd0, 2, 8);
		load_tof(0, 32'd0);
		load_tof(1, 32'd3);
		stack_beam();
		query_sum(1023);
		set_geometry(32'd0, 32'hFFFF_FFFF, 2, 8);
		load_tof(0, 32'hFFFF_FFFF);
		stack_beam();
		query_sum(0);
		query_sum(6);
		query_sum(7);
		set_geometry(32'd0, 32'd1, 0, 8);
		stack_beam();
		set_geometry(32'd0, 32'd1, 3, 0);
		stack_beam();
		query_sum(0);
		set_geometry(32'd10, 32'd1, 127, 2);
		stack_beam();
		query_sum(-1);
		set_geometry(32'hFFFF_FFFF - 32'd2000, 32'd2, 0, 2047);
		stack_beam();
		query_sum(-1024);
		query_sum(23);
		query_sum(24);
	endtask

	task automatic test_random_scans();
		int nch, nt, r, phase;
		logic [31:0] per;
		phase = 0;
		while (items_sent < 1100) begin
			per = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 4);
			set_geometry($urandom_range(0, 1200), per, $urandom_range(1, 8),
				$urandom_range(1, 40));
			nch = eff_channels();
			nt = eff_samples();
			no_gaps = (phase % 4) == 3;
			repeat ($urandom_range(30, 60)) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					load_trace($urandom_range(0, nch - 1), $urandom_range(0, nt - 1),
						16'($urandom));
				else if (r < 55)
					load_tof($urandom_range(0, nch - 1), ($urandom_range(0, 9) == 0) ?
						$urandom : 32'd1000 + $urandom_range(0, 200));
				else if (r < 62)
					stack_beam();
				else if (r < 85)
					query_sum(int'($urandom_range(0, nt + 16)) - 8);
				else if (r < 95)
					load_trace($urandom_range(0, NCH - 1), $urandom_range(0, NSMP - 1),
						16'($urandom));
				else
					query_sum($urandom);
			end
			stack_beam();
			query_sum(int'($urandom_range(0, nt)) - 1);
			phase++;
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dss_pkg::CFG_START_TIME;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = dss_pkg::OP_LOAD_SAMPLE;
		m_tready = 1'b0;
		errors = 0;
		items_sent = 0;
		stacks_sent = 0;
		queries_sent = 0;
		results_seen = 0;
		no_gaps = 1'b0;
		cycles = 0;
		start_ticks = 32'd0;
		period_ticks = 32'd1;
		chan_count = 7'd64;
		smp_count = 11'd1024;
		ref_sample = 0;
		for (int j = 0; j < NSMP; j++) beam_sums[j] = '0;
		for (int i = 0; i < NCH; i++) begin
			tof_ok[i] = 1'b0;
			for (int j = 0; j < NSMP; j++) trace_ok[i][j] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_all_channels();
		test_saturation();
		test_timing_edges();
		test_random_scans();
		wait_idle();
		$display("Sent %0d items (%0d stacks, %0d queries), checked %0d results.",
			items_sent, stacks_sent, queries_sent, results_seen);
		$display("Covered every channel, clamped counts, zero and extreme periods, extreme amplitudes and short random records.");
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/dss_pkg.sv
sv/dss_ram.sv
sv/dss_div.sv
sv/dss_dp.sv
sv/dss_ctrl.sv
sv/delay_and_sum_stacker_top.sv
tb/testbench.sv
